// ===== rtl/core/tfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared types, constants and the byte-wide CRC-32 step of the frame deframer.
// ----------------------------------------------------------------------------
package tfd_pkg;

  localparam int HEADER_BYTES = 24;
  localparam int HDR_BITS     = HEADER_BYTES * 8;
  localparam int HCNT_W       = $clog2(HEADER_BYTES + 1);

  localparam logic [31:0] FRAME_MAGIC = 32'h53414B4E;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
  localparam logic [15:0] FLAG_ENC    = 16'h0001;
  localparam logic [15:0] FLAG_CMP    = 16'h0002;

  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd16777216;
  localparam logic [7:0]  DATA_TYPE_RST   = 8'd2;

  // configuration register indexes
  localparam logic [7:0] REG_MAX_PAYLOAD = 8'd0;
  localparam logic [7:0] REG_DATA_TYPE   = 8'd1;

  // result item kinds
  localparam logic [1:0] KIND_ABSORB   = 2'd0;
  localparam logic [1:0] KIND_HDR_DONE = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD  = 2'd2;
  localparam logic [1:0] KIND_STOPPED  = 2'd3;

  // crc verdicts
  localparam logic [1:0] VERDICT_NONE     = 2'd0;
  localparam logic [1:0] VERDICT_MATCH    = 2'd1;
  localparam logic [1:0] VERDICT_MISMATCH = 2'd2;

  // fault codes
  localparam logic [1:0] FAULT_NONE      = 2'd0;
  localparam logic [1:0] FAULT_MAGIC     = 2'd1;
  localparam logic [1:0] FAULT_OVERSIZE  = 2'd2;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] flags_t;
  typedef logic [31:0] word32_t;

  typedef struct packed {
    logic [1:0] item_kind;
    byte_t      frame_kind;
    flags_t     frame_flags;
    word32_t    chunk_number;
    word32_t    payload_length;
    word32_t    plain_length;
    byte_t      data_byte;
    logic       frame_end;
    logic [1:0] crc_verdict;
    logic [1:0] fault_code;
  } res_t;

  function automatic word32_t crc_byte(word32_t crc, byte_t b);
    word32_t c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic [1:0] crc_verdict_f(byte_t kind, flags_t flags, byte_t code,
                                               word32_t crc, word32_t hdr_crc);
    logic [1:0] v;
    if (kind != code || (flags & (FLAG_ENC | FLAG_CMP)) != 16'd0) begin
      v = VERDICT_NONE;
    end else if ((crc ^ CRC_INIT) == hdr_crc) begin
      v = VERDICT_MATCH;
    end else begin
      v = VERDICT_MISMATCH;
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/tfd_if.sv =====
// ----------------------------------------------------------------------------
// tfd interfaces
// Valid/ready channels of the frame deframer: byte input, result, config.
// ----------------------------------------------------------------------------
interface tfd_rx_if import tfd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfd_res_if import tfd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  byte_t      frame_kind;
  flags_t     frame_flags;
  word32_t    chunk_number;
  word32_t    payload_length;
  word32_t    plain_length;
  byte_t      data_byte;
  logic       frame_end;
  logic [1:0] crc_verdict;
  logic [1:0] fault_code;

  modport source (output valid, output item_kind, output frame_kind, output frame_flags,
                  output chunk_number, output payload_length, output plain_length,
                  output data_byte, output frame_end, output crc_verdict,
                  output fault_code, input ready);
  modport sink   (input valid, input item_kind, input frame_kind, input frame_flags,
                  input chunk_number, input payload_length, input plain_length,
                  input data_byte, input frame_end, input crc_verdict,
                  input fault_code, output ready);
endinterface

interface tfd_cfg_if import tfd_pkg::*; ();
  logic    valid;
  logic    ready;
  byte_t   index;
  word32_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/transfer_frame_deframer_crc_unit.sv =====
// ----------------------------------------------------------------------------
// transfer_frame_deframer_crc_unit
// Length-prefixed frame deframer: header parse, payload pass-through, CRC-32.
// ----------------------------------------------------------------------------
// rx carries one received byte per word. Each accepted byte yields exactly one
// result word on tx: header byte absorbed, header complete, payload byte, or
// stopped. The 24-byte big-endian header is gathered in a shift register;
// payload bytes pass through while a byte-wide CRC-32 runs over them, and the
// last payload byte of an unencrypted, uncompressed data chunk carries the
// CRC verdict. A bad magic or oversize payload stops the block until reset.
// Results are registered; throughput is one word per cycle while tx takes
// them, set by the combinational CRC byte update and header compare.
// A two-entry output stage (result register plus skid) keeps rx ready for one
// more word while tx is stalled; rx ready drops only when both are full.
// cfg takes register writes at any time (ready is always high); they are meant
// for idle periods and apply to later headers (type code: to later verdicts).
// Reset (rst, synchronous) clears the parser, the CRC, the stop state, the
// output stage and sets the registers to their defaults. No clearing pass.
// ----------------------------------------------------------------------------
module transfer_frame_deframer_crc_unit import tfd_pkg::*; (
  input logic        clk,
  input logic        rst,
  tfd_rx_if.sink     rx,
  tfd_res_if.source  tx,
  tfd_cfg_if.sink    cfg
);

  logic [HCNT_W-1:0]   header_count, header_count_next;
  logic [HDR_BITS-1:0] header_shift;
  word32_t             bytes_left, bytes_left_next;
  word32_t             running_crc, running_crc_next;
  logic                stopped_flag, stopped_flag_next;
  logic [1:0]          fault_held, fault_held_next;
  word32_t             max_payload_bytes;
  byte_t               data_chunk_type_code;

  res_t                out_q, skid_q, res;
  logic                out_valid, skid_valid;

  logic                rx_fire, tx_fire, hdr_shift_en, hdr_done;
  logic [HDR_BITS-1:0] hdr_new, hdr_src;
  word32_t             crc_step;
  byte_t               b;

  assign b        = rx.rx_byte;
  assign rx.ready = !skid_valid;
  assign rx_fire  = rx.valid && rx.ready;
  assign tx_fire  = out_valid && tx.ready;
  assign cfg.ready = 1'b1;

  assign hdr_new  = {header_shift[HDR_BITS-9:0], b};
  assign crc_step = crc_byte(running_crc, b);

  always_comb begin
    header_count_next = header_count;
    bytes_left_next   = bytes_left;
    running_crc_next  = running_crc;
    stopped_flag_next = stopped_flag;
    fault_held_next   = fault_held;
    hdr_shift_en      = 1'b0;
    hdr_done          = 1'b0;
    hdr_src           = header_shift;
    res               = '0;

    if (stopped_flag) begin
      res.item_kind  = KIND_STOPPED;
      res.fault_code = fault_held;
    end else if (bytes_left != 32'd0) begin
      running_crc_next = crc_step;
      bytes_left_next  = bytes_left - 32'd1;
      res.item_kind    = KIND_PAYLOAD;
      res.data_byte    = b;
      if (bytes_left_next == 32'd0) begin
        res.frame_end   = 1'b1;
        res.crc_verdict = crc_verdict_f(header_shift[151:144], header_shift[143:128],
                                        data_chunk_type_code, crc_step,
                                        header_shift[31:0]);
      end
    end else begin
      hdr_shift_en = 1'b1;
      if (header_count == HCNT_W'(HEADER_BYTES - 1)) begin
        hdr_done          = 1'b1;
        hdr_src           = hdr_new;
        header_count_next = '0;
        if (hdr_new[191:160] != FRAME_MAGIC) begin
          stopped_flag_next = 1'b1;
          fault_held_next   = FAULT_MAGIC;
          res.item_kind     = KIND_STOPPED;
          res.fault_code    = FAULT_MAGIC;
        end else if (hdr_new[95:64] > max_payload_bytes) begin
          stopped_flag_next = 1'b1;
          fault_held_next   = FAULT_OVERSIZE;
          res.item_kind     = KIND_STOPPED;
          res.fault_code    = FAULT_OVERSIZE;
        end else begin
          res.item_kind    = KIND_HDR_DONE;
          running_crc_next = CRC_INIT;
          bytes_left_next  = hdr_new[95:64];
          if (hdr_new[95:64] == 32'd0) begin
            res.frame_end   = 1'b1;
            res.crc_verdict = crc_verdict_f(hdr_new[151:144], hdr_new[143:128],
                                            data_chunk_type_code, CRC_INIT,
                                            hdr_new[31:0]);
          end
        end
      end else begin
        header_count_next = header_count + HCNT_W'(1);
        res.item_kind     = KIND_ABSORB;
      end
    end

    if (stopped_flag || bytes_left != 32'd0 || hdr_done) begin
      res.frame_kind     = hdr_src[151:144];
      res.frame_flags    = hdr_src[143:128];
      res.chunk_number   = hdr_src[127:96];
      res.payload_length = hdr_src[95:64];
      res.plain_length   = hdr_src[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
      bytes_left   <= '0;
      running_crc  <= CRC_INIT;
      stopped_flag <= 1'b0;
      fault_held   <= FAULT_NONE;
    end else if (rx_fire) begin
      header_count <= header_count_next;
      bytes_left   <= bytes_left_next;
      running_crc  <= running_crc_next;
      stopped_flag <= stopped_flag_next;
      fault_held   <= fault_held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_fire && hdr_shift_en) begin
      header_shift <= hdr_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_bytes    <= MAX_PAYLOAD_RST;
      data_chunk_type_code <= DATA_TYPE_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_MAX_PAYLOAD: max_payload_bytes    <= cfg.data;
        REG_DATA_TYPE:   data_chunk_type_code <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (tx_fire) begin
        out_q      <= skid_q;
        skid_valid <= 1'b0;
      end
    end else if (rx_fire) begin
      if (!out_valid || tx_fire) begin
        out_q     <= res;
        out_valid <= 1'b1;
      end else begin
        skid_q     <= res;
        skid_valid <= 1'b1;
      end
    end else if (tx_fire) begin
      out_valid <= 1'b0;
    end
  end

  assign tx.valid          = out_valid;
  assign tx.item_kind      = out_q.item_kind;
  assign tx.frame_kind     = out_q.frame_kind;
  assign tx.frame_flags    = out_q.frame_flags;
  assign tx.chunk_number   = out_q.chunk_number;
  assign tx.payload_length = out_q.payload_length;
  assign tx.plain_length   = out_q.plain_length;
  assign tx.data_byte      = out_q.data_byte;
  assign tx.frame_end      = out_q.frame_end;
  assign tx.crc_verdict    = out_q.crc_verdict;
  assign tx.fault_code     = out_q.fault_code;

`ifndef NO_ASSERTIONS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a word while the output register is empty");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped_flag |=> stopped_flag)
    else $error("stop state left without reset");

  a_fault_matches_stop: assert property (@(posedge clk) disable iff (rst)
    stopped_flag == (fault_held != FAULT_NONE))
    else $error("held fault disagrees with stop state");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    header_count < HCNT_W'(HEADER_BYTES))
    else $error("header count out of range");

  a_payload_no_header: assert property (@(posedge clk) disable iff (rst)
    bytes_left != 32'd0 |-> header_count == '0)
    else $error("payload in flight with a partial header");
`endif

endmodule

// ===== verif/transfer_frame_deframer_crc_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transfer_frame_deframer_crc_unit_tb
// Self-checking bench for the length-prefixed frame deframer. Frames with
// random headers and payloads go in one byte per word. An in-bench model of
// the header parser, payload counter and CRC-32 predicts every result word,
// and each word is compared field by field. The run sweeps both registers,
// stalls the result side for a long stretch, pauses the input until the
// results have drained, and ends by driving the block into its stop state.
// ----------------------------------------------------------------------------
module transfer_frame_deframer_crc_unit_tb;
  import tfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned STALL_CYCLES = 300;

  logic clk;
  logic rst;

  tfd_rx_if  rx_ch ();
  tfd_res_if res_ch ();
  tfd_cfg_if cfg_ch ();

  transfer_frame_deframer_crc_unit uut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .tx  (res_ch),
    .cfg (cfg_ch)
  );

  // deframer model state
  byte_t       hdr_bytes [HEADER_BYTES];
  int unsigned hdr_fill;
  word32_t     payload_due;
  word32_t     crc_acc;
  logic        halted;
  logic [1:0]  halt_fault;
  word32_t     max_payload_cfg;
  byte_t       data_type_cfg;

  res_t        expected_results [$];

  int unsigned cycle_count;
  int unsigned idle_pct;
  int unsigned stall_kick;
  int unsigned mismatch_count;
  int unsigned results_seen;
  int unsigned bytes_sent;
  int unsigned frames_sent;
  int unsigned crc_matches;
  int unsigned crc_mismatches;
  int unsigned crc_unchecked;

  function automatic word32_t crc32_update(word32_t c, byte_t b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic word32_t hdr_be32(int pos);
    return {hdr_bytes[pos], hdr_bytes[pos+1], hdr_bytes[pos+2], hdr_bytes[pos+3]};
  endfunction

  function automatic res_t header_fields();
    res_t r;
    r                = '0;
    r.frame_kind     = hdr_bytes[5];
    r.frame_flags    = {hdr_bytes[6], hdr_bytes[7]};
    r.chunk_number   = hdr_be32(8);
    r.payload_length = hdr_be32(12);
    r.plain_length   = hdr_be32(16);
    return r;
  endfunction

  function automatic logic [1:0] chunk_verdict();
    flags_t f;
    logic [1:0] v;
    f = {hdr_bytes[6], hdr_bytes[7]};
    if (hdr_bytes[5] != data_type_cfg || (f & (FLAG_ENC | FLAG_CMP)) != 16'd0) begin
      v = VERDICT_NONE;
      crc_unchecked++;
    end else if ((crc_acc ^ CRC_INIT) == hdr_be32(20)) begin
      v = VERDICT_MATCH;
      crc_matches++;
    end else begin
      v = VERDICT_MISMATCH;
      crc_mismatches++;
    end
    return v;
  endfunction

  function automatic void reset_model();
    foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
    hdr_fill        = 0;
    payload_due     = '0;
    crc_acc         = CRC_INIT;
    halted          = 1'b0;
    halt_fault      = FAULT_NONE;
    max_payload_cfg = MAX_PAYLOAD_RST;
    data_type_cfg   = DATA_TYPE_RST;
  endfunction

  function automatic void predict_deframe(byte_t b);
    res_t r;
    r = '0;
    if (halted) begin
      r            = header_fields();
      r.item_kind  = KIND_STOPPED;
      r.fault_code = halt_fault;
    end else if (payload_due != 0) begin
      crc_acc     = crc32_update(crc_acc, b);
      payload_due = payload_due - 1;
      r           = header_fields();
      r.item_kind = KIND_PAYLOAD;
      r.data_byte = b;
      if (payload_due == 0) begin
        r.frame_end   = 1'b1;
        r.crc_verdict = chunk_verdict();
      end
    end else begin
      hdr_bytes[hdr_fill] = b;
      hdr_fill++;
      if (hdr_fill < HEADER_BYTES) begin
        r.item_kind = KIND_ABSORB;
      end else begin
        hdr_fill = 0;
        r        = header_fields();
        if (hdr_be32(0) != FRAME_MAGIC) begin
          halted     = 1'b1;
          halt_fault = FAULT_MAGIC;
        end else if (hdr_be32(12) > max_payload_cfg) begin
          halted     = 1'b1;
          halt_fault = FAULT_OVERSIZE;
        end
        if (halted) begin
          r.item_kind  = KIND_STOPPED;
          r.fault_code = halt_fault;
        end else begin
          r.item_kind = KIND_HDR_DONE;
          crc_acc     = CRC_INIT;
          payload_due = hdr_be32(12);
          if (payload_due == 0) begin
            r.frame_end   = 1'b1;
            r.crc_verdict = chunk_verdict();
          end
        end
      end
    end
    expected_results.push_back(r);
  endfunction

  function automatic string field_diffs(res_t want, res_t got);
    string s;
    s = "";
    if (want.item_kind != got.item_kind)
      s = {s, $sformatf(" item_kind %0d/%0d", want.item_kind, got.item_kind)};
    if (want.frame_kind != got.frame_kind)
      s = {s, $sformatf(" frame_kind %h/%h", want.frame_kind, got.frame_kind)};
    if (want.frame_flags != got.frame_flags)
      s = {s, $sformatf(" frame_flags %h/%h", want.frame_flags, got.frame_flags)};
    if (want.chunk_number != got.chunk_number)
      s = {s, $sformatf(" chunk_number %h/%h", want.chunk_number, got.chunk_number)};
    if (want.payload_length != got.payload_length)
      s = {s, $sformatf(" payload_length %h/%h", want.payload_length, got.payload_length)};
    if (want.plain_length != got.plain_length)
      s = {s, $sformatf(" plain_length %h/%h", want.plain_length, got.plain_length)};
    if (want.data_byte != got.data_byte)
      s = {s, $sformatf(" data_byte %h/%h", want.data_byte, got.data_byte)};
    if (want.frame_end != got.frame_end)
      s = {s, $sformatf(" frame_end %0d/%0d", want.frame_end, got.frame_end)};
    if (want.crc_verdict != got.crc_verdict)
      s = {s, $sformatf(" crc_verdict %0d/%0d", want.crc_verdict, got.crc_verdict)};
    if (want.fault_code != got.fault_code)
      s = {s, $sformatf(" fault_code %0d/%0d", want.fault_code, got.fault_code)};
    return s;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  // result side ready, with random idling and a long hold-off on request
  initial begin : res_ready_gen
    int unsigned stall_seen;
    int unsigned stall_left;
    stall_seen   = 0;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_kick != stall_seen) begin
        stall_seen = stall_kick;
        stall_left = STALL_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t  got;
    res_t  want;
    string diffs;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.item_kind      = res_ch.item_kind;
      got.frame_kind     = res_ch.frame_kind;
      got.frame_flags    = res_ch.frame_flags;
      got.chunk_number   = res_ch.chunk_number;
      got.payload_length = res_ch.payload_length;
      got.plain_length   = res_ch.plain_length;
      got.data_byte      = res_ch.data_byte;
      got.frame_end      = res_ch.frame_end;
      got.crc_verdict    = res_ch.crc_verdict;
      got.fault_code     = res_ch.fault_code;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d: unexpected word, kind %0d", results_seen, got.item_kind);
      end else begin
        want  = expected_results.pop_front();
        diffs = field_diffs(want, got);
        if (diffs != "") begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d mismatch (expected/actual):%s", results_seen, diffs);
        end
      end
      results_seen++;
    end
  end

  task automatic send_byte(byte_t b);
    while ($urandom_range(99) < idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    predict_deframe(b);
    bytes_sent++;
  endtask

  task automatic send_header(logic [HDR_BITS-1:0] hv);
    for (int i = 0; i < HEADER_BYTES; i++) begin
      send_byte(hv[HDR_BITS-1-8*i -: 8]);
    end
  endtask

  task automatic send_frame(byte_t ftype, flags_t flags, int unsigned len, bit crc_ok);
    byte_t               body [];
    word32_t             crc;
    logic [HDR_BITS-1:0] hv;
    body = new[len];
    crc  = CRC_INIT;
    foreach (body[i]) begin
      body[i] = byte_t'($urandom);
      crc     = crc32_update(crc, body[i]);
    end
    crc = crc ^ CRC_INIT;
    if (!crc_ok) begin
      crc = crc ^ (32'h1 << $urandom_range(31));
    end
    hv = {FRAME_MAGIC, byte_t'($urandom), ftype, flags, word32_t'($urandom),
          word32_t'(len), word32_t'($urandom), crc};
    send_header(hv);
    foreach (body[i]) send_byte(body[i]);
    frames_sent++;
  endtask

  task automatic send_random_frames(int unsigned budget);
    int unsigned start;
    int unsigned len;
    int unsigned pick;
    byte_t       ftype;
    flags_t      flags;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        len = $urandom_range(300, 100);
      end else if (pick < 15) begin
        len = 0;
      end else begin
        len = $urandom_range(40, 1);
      end
      if (max_payload_cfg <= 300 && $urandom_range(9) == 0) begin
        len = max_payload_cfg;
      end
      if (len > max_payload_cfg) begin
        len = max_payload_cfg;
      end
      ftype = ($urandom_range(99) < 70) ? data_type_cfg : byte_t'($urandom);
      flags = flags_t'($urandom);
      if ($urandom_range(99) < 70) begin
        flags[1:0] = 2'b00;
      end
      send_frame(ftype, flags, len, $urandom_range(99) < 80);
    end
  endtask

  task automatic drain_results();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(byte_t idx, word32_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_MAX_PAYLOAD) begin
      max_payload_cfg = value;
    end else if (idx == REG_DATA_TYPE) begin
      data_type_cfg = value[7:0];
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(word32_t max_len, byte_t type_code);
    drain_results();
    cfg_write(REG_MAX_PAYLOAD, max_len);
    cfg_write(REG_DATA_TYPE, {24'd0, type_code});
  endtask

  task automatic test_empty_frame();
    // checked frame, no payload, header crc of the empty input
    send_header({FRAME_MAGIC, 8'hFF, data_type_cfg, 16'hFFFC, 32'hFFFFFFFF,
                 32'h0, 32'h0, 32'h0});
    frames_sent++;
  endtask

  task automatic test_random_frames();
    send_random_frames(300);
  endtask

  task automatic test_no_idle_stretch();
    idle_pct = 0;
    send_random_frames(200);
    idle_pct = 20;
  endtask

  task automatic test_register_sweep();
    apply_setting(32'd0, 8'h00);
    send_random_frames(120);
    apply_setting(32'hFFFFFFFF, 8'hFF);
    send_random_frames(120);
    apply_setting(word32_t'($urandom_range(64, 1)), byte_t'($urandom));
    send_random_frames(120);
    // writes to unmapped indexes must leave both registers alone
    drain_results();
    cfg_write(8'hFF, word32_t'($urandom));
    cfg_write(byte_t'($urandom_range(254, 2)), word32_t'($urandom));
    send_random_frames(40);
    apply_setting(MAX_PAYLOAD_RST, DATA_TYPE_RST);
    send_random_frames(80);
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_kick++;
    send_random_frames(160);
    idle_pct = 20;
  endtask

  task automatic test_drain_pause();
    send_random_frames(70);
    drain_results();
    send_random_frames(70);
  endtask

  task automatic test_stop_state();
    logic [HDR_BITS-1:0] hv;
    word32_t             magic;
    word32_t             size;
    drain_results();
    if ($urandom_range(1) == 1) begin
      // bad magic, sometimes with an oversize length too since magic wins
      magic = FRAME_MAGIC ^ (32'h1 << $urandom_range(31));
      size  = ($urandom_range(1) == 1) ? 32'hFFFFFFFF : word32_t'($urandom_range(40));
    end else begin
      cfg_write(REG_MAX_PAYLOAD, word32_t'($urandom_range(1000)));
      magic = FRAME_MAGIC;
      size  = max_payload_cfg + 1;
    end
    hv = {magic, byte_t'($urandom), data_type_cfg, flags_t'($urandom) & 16'hFFFC,
          word32_t'($urandom), size, word32_t'($urandom), word32_t'($urandom)};
    send_header(hv);
    frames_sent++;
    repeat (20) send_byte(byte_t'($urandom));
  endtask

  initial begin
    rst            = 1'b1;
    rx_ch.valid    = 1'b0;
    rx_ch.rx_byte  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    idle_pct       = 20;
    stall_kick     = 0;
    mismatch_count = 0;
    results_seen   = 0;
    bytes_sent     = 0;
    frames_sent    = 0;
    crc_matches    = 0;
    crc_mismatches = 0;
    crc_unchecked  = 0;
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_frame();
    test_random_frames();
    test_no_idle_stretch();
    test_register_sweep();
    test_backpressure();
    test_drain_pause();
    test_stop_state();
    drain_results();
    repeat (5) @(posedge clk);

    $display("%0d bytes in %0d frames, %0d result words: crc match %0d, mismatch %0d,",
             bytes_sent, frames_sent, results_seen, crc_matches, crc_mismatches);
    $display("unchecked %0d; register sweep at both extremes, long result stall,",
             crc_unchecked);
    $display("stop state fault %0d; %0d mismatches", halt_fault, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
